FILE: hdl/salc_pkg.sv
// salc_pkg: shared types and codes for the set-associative LRU cache tag model.
// Payload structs, outcome codes, register indexes and the controller states.
// No dependencies.
`timescale 1ns / 1ps

package salc_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 62;
  localparam int COUNT_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // Reset values of the registers
  localparam logic [2:0] SET_BITS_RST    = 3'd4;
  localparam logic [5:0] BLOCK_BITS_RST  = 6'd4;
  localparam logic [2:0] WAYS_IN_USE_RST = 3'd1;

  // Per-access result code
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  // Controller states: idle, lookup over the set row, update and write back
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOOK = 2'd1,
    ST_UPD  = 2'd2
  } state_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [COUNT_W-1:0] total_hits;
    logic [COUNT_W-1:0] total_misses;
    logic [COUNT_W-1:0] total_evictions;
    logic               last;
  } out_item_t;

endpackage

FILE: hdl/set_assoc_lru_cache_tag_model.sv
// set_assoc_lru_cache_tag_model: tag-only set-associative cache with LRU stamps.
// One row per set in a synchronous memory, read-modify-write per access.
// Depends on salc_pkg.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+--------------------------------------
//   in_     | in  | in_valid/in_ready  | in_data   : op, address
//   out_    | out | out_valid/out_ready| out_data  : outcome, totals, last
//   cfg_    | in  | cfg_we             | cfg_index, cfg_data (no read-back)
//
// A single access item passes accept and row read, lookup and update; a
// modify item then repeats lookup and update, its second access reusing the
// row just written. The row memory read is registered. Reset clears the row
// valid flops at once; no sweep.
// The input is taken only while idle; an access waits in update while the
// output register still holds an untaken result.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tag_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4,
  parameter int STAMP_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  salc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output salc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import salc_pkg::*;

  localparam int ROWS  = 1 << MAX_SET_BITS;
  localparam int SET_W = MAX_SET_BITS;
  localparam int SB_W  = $clog2(MAX_SET_BITS + 1);
  localparam int SBX_W = (SB_W > 3) ? SB_W : 3;
  localparam int SH_W  = ((SBX_W > 6) ? SBX_W : 6) + 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW_W  = $clog2(WAYS + 1);
  localparam int NWX_W = (NW_W > 3) ? NW_W : 3;

  typedef struct packed {
    logic                   valid;
    logic [TAG_W-1:0]       tag;
    logic [STAMP_WIDTH-1:0] stamp;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  // Configuration registers
  logic [2:0] set_bits_r;
  logic [5:0] block_bits_r;
  logic [2:0] ways_in_use_r;

  // Control
  state_t state_r, state_nxt;
  logic   second_r;
  logic   op_r;
  logic   rd_en, upd_fire, upd_wait;

  // Access payload
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;

  // Set row memory and its valid flops
  row_t             mem [ROWS];
  logic [ROWS-1:0]  row_valid_r;
  row_t             rd_row_r;
  logic             rd_rv_r;
  row_t             fwd_row_r;
  row_t             row_r;
  row_t             row_in, new_row;

  // Lookup results
  logic                   hit_c, free_c, have_max_c;
  logic [WAY_W-1:0]       hit_way_c, free_way_c, victim_c;
  logic [STAMP_WIDTH-1:0] maxs_c, mins_c;
  logic                   hit_r, free_r, have_max_r;
  logic [WAY_W-1:0]       hit_way_r, free_way_r, victim_r;
  logic [STAMP_WIDTH-1:0] maxs_r;

  // Totals and output register
  logic [COUNT_W-1:0] hits_r, misses_r, evicts_r;
  logic [COUNT_W-1:0] hits_nxt, misses_nxt, evicts_nxt;
  out_item_t          out_r;
  logic               out_valid_r;

  // Effective configuration
  logic [SBX_W-1:0]  sb_x, sb_eff;
  logic [SET_W-1:0]  set_mask, set_c;
  logic [SH_W-1:0]   shift_c;
  logic [TAG_W-1:0]  tag_c;
  logic [NWX_W-1:0]  nw_x;
  logic [NW_W-1:0]   nw;

  // Address split for the incoming transaction
  always_comb begin
    sb_x     = SBX_W'(set_bits_r);
    sb_eff   = (sb_x > SBX_W'(MAX_SET_BITS)) ? SBX_W'(MAX_SET_BITS) : sb_x;
    set_mask = ~({SET_W{1'b1}} << sb_eff);
    set_c    = SET_W'(in_data.address >> block_bits_r) & set_mask;
    shift_c  = SH_W'(sb_eff) + SH_W'(block_bits_r);
    tag_c    = TAG_W'(in_data.address >> shift_c);
    nw_x     = NWX_W'(ways_in_use_r);
    if (nw_x == '0) begin
      nw_x = NWX_W'(1);
    end else if (nw_x > NWX_W'(WAYS)) begin
      nw_x = NWX_W'(WAYS);
    end
    nw = NW_W'(nw_x);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= SET_BITS_RST;
      block_bits_r  <= BLOCK_BITS_RST;
      ways_in_use_r <= WAYS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:    set_bits_r    <= cfg_data[2:0];
        CFG_BLOCK_BITS:  block_bits_r  <= cfg_data[5:0];
        CFG_WAYS_IN_USE: ways_in_use_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD: begin
        if (!upd_wait) begin
          state_nxt = (op_r && !second_r) ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    upd_wait = out_valid_r && !out_ready;
    in_ready = 1'b0;
    upd_fire = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_LOOK: ;
      ST_UPD:  upd_fire = !upd_wait;
      default: ;
    endcase
    rd_en = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_fire) begin
        second_r <= op_r && !second_r;
      end
    end
  end

  // Latch the transaction
  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_r  <= in_data.op;
      set_r <= set_c;
      tag_r <= tag_c;
    end
  end

  // Row memory: registered read at accept, write back on update
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      mem[set_r] <= new_row;
    end
    if (rd_en) begin
      rd_row_r <= mem[set_c];
      rd_rv_r  <= row_valid_r[set_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (upd_fire) begin
      row_valid_r[set_r] <= 1'b1;
    end
  end

  // Row seen by the lookup: forwarded row on the second access of a modify, else the read row, or zero if never written
  always_comb begin
    if (second_r) begin
      row_in = fwd_row_r;
    end else if (rd_rv_r) begin
      row_in = rd_row_r;
    end else begin
      row_in = '0;
    end
  end

  // Lookup over the ways in use: hit, free way, largest stamp, victim
  always_comb begin
    hit_c      = 1'b0;
    hit_way_c  = '0;
    free_c     = 1'b0;
    free_way_c = '0;
    have_max_c = 1'b0;
    maxs_c     = '0;
    mins_c     = row_in[0].stamp;
    victim_c   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (NW_W'(w) < nw) begin
        if (!row_in[w].valid) begin
          free_c     = 1'b1;
          free_way_c = WAY_W'(w);
        end else begin
          if (!hit_c && row_in[w].tag == tag_r) begin
            hit_c     = 1'b1;
            hit_way_c = WAY_W'(w);
          end
          if (!have_max_c || row_in[w].stamp > maxs_c) begin
            maxs_c     = row_in[w].stamp;
            have_max_c = 1'b1;
          end
        end
        if (row_in[w].stamp < mins_c) begin
          mins_c   = row_in[w].stamp;
          victim_c = WAY_W'(w);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      row_r      <= row_in;
      hit_r      <= hit_c;
      hit_way_r  <= hit_way_c;
      free_r     <= free_c;
      free_way_r <= free_way_c;
      victim_r   <= victim_c;
      have_max_r <= have_max_c;
      maxs_r     <= maxs_c;
    end
  end

  // Update: new stamp, line replacement and saturating totals
  logic [STAMP_WIDTH-1:0] news;
  logic [WAY_W-1:0]       tgt_way;
  outcome_t               outcome_c;

  always_comb begin
    if (!have_max_r) begin
      news = '0;
    end else if (maxs_r == '1) begin
      news = maxs_r;
    end else begin
      news = maxs_r + STAMP_WIDTH'(1);
    end
    if (hit_r) begin
      tgt_way   = hit_way_r;
      outcome_c = OUT_HIT;
    end else if (free_r) begin
      tgt_way   = free_way_r;
      outcome_c = OUT_FILL;
    end else begin
      tgt_way   = victim_r;
      outcome_c = OUT_EVICT;
    end
    new_row = row_r;
    new_row[tgt_way].stamp = news;
    if (!hit_r) begin
      new_row[tgt_way].valid = 1'b1;
      new_row[tgt_way].tag   = tag_r;
    end
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (hit_r) begin
      if (hits_r != '1) hits_nxt = hits_r + COUNT_W'(1);
    end else begin
      if (misses_r != '1) misses_nxt = misses_r + COUNT_W'(1);
      if (!free_r && evicts_r != '1) evicts_nxt = evicts_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      fwd_row_r <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else if (upd_fire) begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_r.outcome         <= outcome_c;
      out_r.total_hits      <= hits_nxt;
      out_r.total_misses    <= misses_nxt;
      out_r.total_evictions <= evicts_nxt;
      out_r.last            <= !op_r || second_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hits_r >= $past(hits_r))
    else $error("hit total went down");

  a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.total_evictions <= out_r.total_misses)
    else $error("more evictions than misses");

  a_second_only_modify: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> op_r && state_r != ST_IDLE)
    else $error("second access outside a modify transaction");

  a_first_of_modify_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire && op_r && !second_r |=> out_valid_r && !out_r.last)
    else $error("first access of a modify flagged as last");

endmodule
